// File: rtl/stt_pkg.sv
// Shared types, token codes and keyword tables for the source text tokenizer.
// Depends on nothing; every rtl file of the tokenizer imports it.
package stt_pkg;

    // room for the most results one input byte can cause
    localparam int MAX_RESULTS = 6;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    // token kinds
    localparam logic [5:0] K_EOF      = 6'd0;
    localparam logic [5:0] K_NONE     = 6'd0;
    localparam logic [5:0] K_STRING   = 6'd1;
    localparam logic [5:0] K_INT      = 6'd2;
    localparam logic [5:0] K_IDENT    = 6'd3;
    localparam logic [5:0] K_KW0      = 6'd4;
    localparam logic [5:0] K_PLUS     = 6'd13;
    localparam logic [5:0] K_MINUS    = 6'd14;
    localparam logic [5:0] K_MUL      = 6'd15;
    localparam logic [5:0] K_DIV      = 6'd16;
    localparam logic [5:0] K_MOD      = 6'd17;
    localparam logic [5:0] K_LPAREN   = 6'd18;
    localparam logic [5:0] K_RPAREN   = 6'd19;
    localparam logic [5:0] K_LBRACE   = 6'd20;
    localparam logic [5:0] K_RBRACE   = 6'd21;
    localparam logic [5:0] K_LBRACKET = 6'd22;
    localparam logic [5:0] K_RBRACKET = 6'd23;
    localparam logic [5:0] K_SEMI     = 6'd24;
    localparam logic [5:0] K_COMMA    = 6'd25;
    localparam logic [5:0] K_ASSIGN   = 6'd26;
    localparam logic [5:0] K_EQ       = 6'd27;
    localparam logic [5:0] K_NOT      = 6'd28;
    localparam logic [5:0] K_NEQ      = 6'd29;
    localparam logic [5:0] K_LT       = 6'd30;
    localparam logic [5:0] K_LTE      = 6'd31;
    localparam logic [5:0] K_GT       = 6'd32;
    localparam logic [5:0] K_GTE      = 6'd33;
    localparam logic [5:0] K_AND      = 6'd34;
    localparam logic [5:0] K_OR       = 6'd35;
    localparam logic [5:0] K_ERROR    = 6'd36;

    // record kinds
    localparam logic REC_VALUE = 1'b0;
    localparam logic REC_DONE  = 1'b1;

    // characters with a role of their own
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_BAR   = 8'h7C;

    // keyword spellings, right-justified, and their lengths
    localparam int NUM_KW = 9;
    localparam logic [47:0] KW_TEXT [NUM_KW] = '{
        "var", "if", "else", "while", "fn", "return", "print", "true", "false"
    };
    localparam logic [2:0] KW_LEN [NUM_KW] = '{
        3'd3, 3'd2, 3'd4, 3'd5, 3'd2, 3'd6, 3'd5, 3'd4, 3'd5
    };

    typedef struct packed {
        logic [7:0] ch;
        logic       final_req;
    } in_item_t;

    typedef struct packed {
        logic        record_kind;
        logic [5:0]  token_kind;
        logic [7:0]  value_char;
        logic [15:0] start_line;
        logic [15:0] start_column;
        logic        last_of_run;
    } result_t;

    typedef result_t [MAX_RESULTS-1:0] result_list_t;

    function automatic logic is_space(logic [7:0] c);
        return (c == 8'h20) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    function automatic logic is_word(logic [7:0] c);
        return is_alpha(c) || is_digit(c) || (c == "_");
    endfunction

    // character i of keyword k, zero past its end
    function automatic logic [7:0] kw_char(int k, logic [2:0] i);
        logic [2:0] pos;
        pos = KW_LEN[k] - 3'd1 - i;
        if (i >= KW_LEN[k])
            return 8'h00;
        return KW_TEXT[k][8*pos +: 8];
    endfunction

    // drop keywords that no longer match the word so far
    function automatic logic [8:0] kw_next(logic [8:0] kc, logic [2:0] il, logic [7:0] c);
        logic [8:0] r;
        r = kc;
        for (int k = 0; k < NUM_KW; k++)
        begin
            if (kc[k] && ((il >= KW_LEN[k]) || (kw_char(k, il) != c)))
                r[k] = 1'b0;
        end
        return r;
    endfunction

    // kind of a finished word: first keyword still matching at full length
    function automatic logic [5:0] ident_kind(logic [8:0] kc, logic [2:0] il);
        logic [5:0] kind;
        kind = K_IDENT;
        for (int k = NUM_KW - 1; k >= 0; k--)
        begin
            if (kc[k] && (KW_LEN[k] == il))
                kind = K_KW0 + 6'(k);
        end
        return kind;
    endfunction

    // operators that always stand alone; K_NONE if not one
    function automatic logic [5:0] single_op(logic [7:0] c);
        case (c)
            "+":     return K_PLUS;
            "-":     return K_MINUS;
            "*":     return K_MUL;
            "%":     return K_MOD;
            "(":     return K_LPAREN;
            ")":     return K_RPAREN;
            "{":     return K_LBRACE;
            "}":     return K_RBRACE;
            "[":     return K_LBRACKET;
            "]":     return K_RBRACKET;
            ";":     return K_SEMI;
            ",":     return K_COMMA;
            default: return K_NONE;
        endcase
    endfunction

    function automatic logic is_pend_start(logic [7:0] c);
        return (c == CH_EQ) || (c == CH_BANG) || (c == CH_LT) || (c == CH_GT) ||
               (c == CH_AMP) || (c == CH_BAR) || (c == CH_SLASH);
    endfunction

    // two-character operator from pending p and next c; K_NONE if no pair
    function automatic logic [5:0] pair_op(logic [7:0] p, logic [7:0] c);
        logic [5:0] kind;
        kind = K_NONE;
        case (p)
            CH_EQ:   if (c == CH_EQ) kind = K_EQ;
            CH_BANG: if (c == CH_EQ) kind = K_NEQ;
            CH_LT:   if (c == CH_EQ) kind = K_LTE;
            CH_GT:   if (c == CH_EQ) kind = K_GTE;
            CH_AMP:  if (c == CH_AMP) kind = K_AND;
            CH_BAR:  if (c == CH_BAR) kind = K_OR;
            default: kind = K_NONE;
        endcase
        return kind;
    endfunction

    // pending character taken alone; K_NONE means a lone & or | (error)
    function automatic logic [5:0] lone_op(logic [7:0] p);
        case (p)
            CH_SLASH: return K_DIV;
            CH_EQ:    return K_ASSIGN;
            CH_BANG:  return K_NOT;
            CH_LT:    return K_LT;
            CH_GT:    return K_GT;
            default:  return K_NONE;
        endcase
    endfunction

endpackage

// File: rtl/stt_scanner.sv
// Scanner state and the single-pass logic that turns one source byte into its result list.
// Depends on stt_pkg.
module stt_scanner #(
    parameter int POSITION_WIDTH = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  fire,
    input  stt_pkg::in_item_t     item,
    output stt_pkg::result_list_t results,
    output logic [stt_pkg::CNT_W-1:0] count
);
    import stt_pkg::*;

    localparam int WW = POSITION_WIDTH + 16;

    typedef logic [POSITION_WIDTH-1:0] pos_t;

    typedef enum logic [2:0] {
        M_IDLE,
        M_IDENT,
        M_NUM,
        M_STR,
        M_COMMENT,
        M_PEND
    } mode_t;

    mode_t      mode_reg, mode_next;
    logic [7:0] pend_reg, pend_next;
    pos_t       line_reg, line_next;
    pos_t       col_reg, col_next;
    pos_t       tok_line_reg, tok_line_next;
    pos_t       tok_col_reg, tok_col_next;
    logic [8:0] kw_reg, kw_cand_next;
    logic [2:0] ilen_reg, ilen_next;

    // positions go out clipped to 16 bits
    function automatic logic [15:0] clip16(pos_t v);
        logic [WW-1:0] w;
        w = WW'(v);
        return (w > WW'(17'h0FFFF)) ? 16'hFFFF : w[15:0];
    endfunction

    function automatic result_t mk_rec(logic rk, logic [5:0] kind, logic [7:0] val,
                                       pos_t ln, pos_t col);
        result_t r;
        r.record_kind  = rk;
        r.token_kind   = kind;
        r.value_char   = val;
        r.start_line   = clip16(ln);
        r.start_column = clip16(col);
        r.last_of_run  = 1'b0;
        return r;
    endfunction

    function automatic pos_t adv_line(logic [7:0] c, pos_t l);
        if ((c == CH_LF) && (l != '1))
            return pos_t'(l + 1'b1);
        return l;
    endfunction

    function automatic pos_t adv_col(logic [7:0] c, pos_t cc);
        if (c == CH_LF)
            return pos_t'(1);
        if (cc != '1)
            return pos_t'(cc + 1'b1);
        return cc;
    endfunction

    // one pass: close the open token, scan the byte, flush at end of source
    always_comb
    begin
        logic [7:0]       c;
        logic             at_end;
        logic             do_idle;
        logic [5:0]       op;
        logic [CNT_W-1:0] n;
        result_list_t     res;

        c       = item.ch;
        at_end  = (item.ch == CH_NUL) || item.final_req;
        do_idle = 1'b0;
        op      = K_NONE;
        n       = '0;
        res     = '0;

        mode_next     = mode_reg;
        pend_next     = pend_reg;
        line_next     = line_reg;
        col_next      = col_reg;
        tok_line_next = tok_line_reg;
        tok_col_next  = tok_col_reg;
        kw_cand_next  = kw_reg;
        ilen_next     = ilen_reg;

        if (c != CH_NUL)
        begin
            case (mode_reg)
                M_IDENT:
                begin
                    if (is_word(c))
                    begin
                        kw_cand_next = kw_next(kw_reg, ilen_reg, c);
                        if (ilen_reg < 3'd7)
                            ilen_next = ilen_reg + 3'd1;
                        res[n] = mk_rec(REC_VALUE, K_IDENT, c, tok_line_reg, tok_col_reg);
                        n = n + 1'b1;
                        line_next = adv_line(c, line_reg);
                        col_next  = adv_col(c, col_reg);
                    end
                    else
                    begin
                        res[n] = mk_rec(REC_DONE, ident_kind(kw_reg, ilen_reg), 8'h00,
                                        tok_line_reg, tok_col_reg);
                        n = n + 1'b1;
                        do_idle = 1'b1;
                    end
                end
                M_NUM:
                begin
                    if (is_digit(c))
                    begin
                        res[n] = mk_rec(REC_VALUE, K_INT, c, tok_line_reg, tok_col_reg);
                        n = n + 1'b1;
                        line_next = adv_line(c, line_reg);
                        col_next  = adv_col(c, col_reg);
                    end
                    else
                    begin
                        res[n] = mk_rec(REC_DONE, K_INT, 8'h00, tok_line_reg, tok_col_reg);
                        n = n + 1'b1;
                        do_idle = 1'b1;
                    end
                end
                M_STR:
                begin
                    if (c == CH_QUOTE)
                    begin
                        res[n] = mk_rec(REC_DONE, K_STRING, 8'h00, tok_line_reg, tok_col_reg);
                        mode_next = M_IDLE;
                    end
                    else
                    begin
                        res[n] = mk_rec(REC_VALUE, K_STRING, c, tok_line_reg, tok_col_reg);
                    end
                    n = n + 1'b1;
                    line_next = adv_line(c, line_reg);
                    col_next  = adv_col(c, col_reg);
                end
                M_COMMENT:
                begin
                    if (c == CH_LF)
                        mode_next = M_IDLE;
                    line_next = adv_line(c, line_reg);
                    col_next  = adv_col(c, col_reg);
                end
                M_PEND:
                begin
                    mode_next = M_IDLE;
                    op = pair_op(pend_reg, c);
                    if ((pend_reg == CH_SLASH) && (c == CH_SLASH))
                    begin
                        mode_next = M_COMMENT;
                        line_next = adv_line(c, line_reg);
                        col_next  = adv_col(c, col_reg);
                    end
                    else if (op != K_NONE)
                    begin
                        res[n] = mk_rec(REC_DONE, op, 8'h00, tok_line_reg, tok_col_reg);
                        n = n + 1'b1;
                        line_next = adv_line(c, line_reg);
                        col_next  = adv_col(c, col_reg);
                    end
                    else
                    begin
                        op = lone_op(pend_reg);
                        if (op != K_NONE)
                        begin
                            res[n] = mk_rec(REC_DONE, op, 8'h00, tok_line_reg, tok_col_reg);
                            n = n + 1'b1;
                        end
                        else
                        begin
                            res[n] = mk_rec(REC_VALUE, K_ERROR, pend_reg,
                                            tok_line_reg, tok_col_reg);
                            n = n + 1'b1;
                            res[n] = mk_rec(REC_DONE, K_ERROR, 8'h00,
                                            tok_line_reg, tok_col_reg);
                            n = n + 1'b1;
                        end
                        do_idle = 1'b1;
                    end
                end
                default:
                begin
                    do_idle = 1'b1;
                end
            endcase

            // byte seen between tokens
            if (do_idle)
            begin
                mode_next = M_IDLE;
                if (!is_space(c))
                begin
                    tok_line_next = line_next;
                    tok_col_next  = col_next;
                    op = single_op(c);
                    if (c == CH_QUOTE)
                    begin
                        mode_next = M_STR;
                    end
                    else if (is_digit(c))
                    begin
                        res[n] = mk_rec(REC_VALUE, K_INT, c, tok_line_next, tok_col_next);
                        n = n + 1'b1;
                        mode_next = M_NUM;
                    end
                    else if (is_alpha(c) || (c == "_"))
                    begin
                        kw_cand_next = kw_next(9'h1FF, 3'd0, c);
                        ilen_next = 3'd1;
                        res[n] = mk_rec(REC_VALUE, K_IDENT, c, tok_line_next, tok_col_next);
                        n = n + 1'b1;
                        mode_next = M_IDENT;
                    end
                    else if (op != K_NONE)
                    begin
                        res[n] = mk_rec(REC_DONE, op, 8'h00, tok_line_next, tok_col_next);
                        n = n + 1'b1;
                    end
                    else if (is_pend_start(c))
                    begin
                        pend_next = c;
                        mode_next = M_PEND;
                    end
                    else
                    begin
                        res[n] = mk_rec(REC_VALUE, K_ERROR, c, tok_line_next, tok_col_next);
                        n = n + 1'b1;
                        res[n] = mk_rec(REC_DONE, K_ERROR, 8'h00, tok_line_next, tok_col_next);
                        n = n + 1'b1;
                    end
                end
                line_next = adv_line(c, line_next);
                col_next  = adv_col(c, col_next);
            end
        end

        // end of source: close what is open, then eof and a fresh start
        if (at_end)
        begin
            case (mode_next)
                M_IDENT:
                begin
                    res[n] = mk_rec(REC_DONE, ident_kind(kw_cand_next, ilen_next), 8'h00,
                                    tok_line_next, tok_col_next);
                    n = n + 1'b1;
                end
                M_NUM:
                begin
                    res[n] = mk_rec(REC_DONE, K_INT, 8'h00, tok_line_next, tok_col_next);
                    n = n + 1'b1;
                end
                M_STR:
                begin
                    res[n] = mk_rec(REC_DONE, K_STRING, 8'h00, tok_line_next, tok_col_next);
                    n = n + 1'b1;
                end
                M_PEND:
                begin
                    op = lone_op(pend_next);
                    if (op != K_NONE)
                    begin
                        res[n] = mk_rec(REC_DONE, op, 8'h00, tok_line_next, tok_col_next);
                        n = n + 1'b1;
                    end
                    else
                    begin
                        res[n] = mk_rec(REC_VALUE, K_ERROR, pend_next,
                                        tok_line_next, tok_col_next);
                        n = n + 1'b1;
                        res[n] = mk_rec(REC_DONE, K_ERROR, 8'h00, tok_line_next, tok_col_next);
                        n = n + 1'b1;
                    end
                end
                default:
                begin
                    n = n;
                end
            endcase
            res[n] = mk_rec(REC_DONE, K_EOF, 8'h00, line_next, col_next);
            n = n + 1'b1;

            mode_next     = M_IDLE;
            pend_next     = 8'h00;
            line_next     = pos_t'(1);
            col_next      = pos_t'(1);
            tok_line_next = pos_t'(1);
            tok_col_next  = pos_t'(1);
            kw_cand_next  = 9'h1FF;
            ilen_next     = 3'd0;
        end

        // flag the last result of this byte
        if (n != '0)
            res[n - 1'b1].last_of_run = 1'b1;

        results = res;
        count   = n;
    end

    // scanner state, advanced once per byte taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= M_IDLE;
            pend_reg     <= 8'h00;
            line_reg     <= pos_t'(1);
            col_reg      <= pos_t'(1);
            tok_line_reg <= pos_t'(1);
            tok_col_reg  <= pos_t'(1);
            kw_reg       <= 9'h1FF;
            ilen_reg     <= 3'd0;
        end
        else if (fire)
        begin
            mode_reg     <= mode_next;
            pend_reg     <= pend_next;
            line_reg     <= line_next;
            col_reg      <= col_next;
            tok_line_reg <= tok_line_next;
            tok_col_reg  <= tok_col_next;
            kw_reg       <= kw_cand_next;
            ilen_reg     <= ilen_next;
        end
    end

endmodule

// File: rtl/source_text_tokenizer_unit.sv
// Top level of the source text tokenizer: input register, scanner, result run buffer.
// Depends on stt_pkg and stt_scanner.
//
// Usage: source bytes come in on the src channel (src_valid, src_stall, src_item), one
// request per byte. Token records leave on the tok channel (tok_valid, tok_stall,
// tok_item). A byte lands in an input register; once the run buffer is free, the
// scanner turns it into its whole run of zero to five records at once and loads them
// into the run buffer, which sends one record per cycle while tok_stall is low. The last
// record of each byte has last_of_run set. Bytes that make at most one record each
// pass at one byte per cycle while tok_stall is low; a byte with more records holds
// the buffer until its last record is taken, as the run buffer has a single output port.
// A stalled receiver freezes the current record; the input register keeps taking
// one byte and then raises src_stall until the buffer drains.
// Reset clears the buffers and puts the scanner at line 1, column 1 between tokens.
// A zero byte or final_req ends the source: open token closed, eof sent, state reset.
module source_text_tokenizer_unit #(
    parameter int POSITION_WIDTH = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              src_valid,
    output logic              src_stall,
    input  stt_pkg::in_item_t src_item,
    output logic              tok_valid,
    input  logic              tok_stall,
    output stt_pkg::result_t  tok_item
);
    import stt_pkg::*;

    logic             inq_valid_reg, inq_valid_next;
    in_item_t         inq_item_reg;
    result_list_t     run_reg;
    logic [CNT_W-1:0] run_cnt_reg, run_cnt_next;
    logic [CNT_W-1:0] run_idx_reg, run_idx_next;

    result_list_t     scan_results;
    logic [CNT_W-1:0] scan_cnt;
    logic             src_take;
    logic             tok_take;
    logic             run_free;
    logic             load_run;

    stt_scanner #(
        .POSITION_WIDTH(POSITION_WIDTH)
    ) u_scanner (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (load_run),
        .item    (inq_item_reg),
        .results (scan_results),
        .count   (scan_cnt)
    );

    // handshake decode
    assign tok_valid = (run_idx_reg != run_cnt_reg);
    assign tok_item  = run_reg[run_idx_reg];
    assign tok_take  = tok_valid && !tok_stall;
    assign run_free  = !tok_valid || (tok_take && (run_idx_reg + 1'b1 == run_cnt_reg));
    assign load_run  = inq_valid_reg && run_free;
    assign src_stall = inq_valid_reg && !run_free;
    assign src_take  = src_valid && !src_stall;

    // next values for input register and run pointers
    always_comb
    begin
        inq_valid_next = inq_valid_reg;
        if (src_take)
            inq_valid_next = 1'b1;
        else if (load_run)
            inq_valid_next = 1'b0;

        run_cnt_next = run_cnt_reg;
        run_idx_next = run_idx_reg;
        if (load_run)
        begin
            run_cnt_next = scan_cnt;
            run_idx_next = '0;
        end
        else if (tok_take)
        begin
            run_idx_next = run_idx_reg + 1'b1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inq_valid_reg <= 1'b0;
            run_cnt_reg   <= '0;
            run_idx_reg   <= '0;
        end
        else
        begin
            inq_valid_reg <= inq_valid_next;
            run_cnt_reg   <= run_cnt_next;
            run_idx_reg   <= run_idx_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (src_take)
            inq_item_reg <= src_item;
        if (load_run)
            run_reg <= scan_results;
    end

    // read pointer never passes the end of the run
    assert property (@(posedge clk) disable iff (!rst_n)
        run_idx_reg <= run_cnt_reg)
        else $error("run read pointer past end of run");

    // last_of_run marks exactly the final record of the buffered run
    assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid |-> (tok_item.last_of_run == (run_idx_reg + 1'b1 == run_cnt_reg)))
        else $error("last_of_run out of step with run buffer");

    // a stalled record stays put in the run buffer
    assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && tok_stall |=> tok_valid && $stable(run_idx_reg))
        else $error("run buffer moved under stall");

endmodule
